// ===== hdl/rlcf_pkg.sv =====
package rlcf_pkg;

    // Timing constants in milliseconds.
    localparam int TICK_MS = 10;
    localparam int WRAP_MS = 1000;
    localparam int UNIT_MS = 20;

    // Widths of the fields and of the state.
    localparam int MS_W    = 10;
    localparam int LEVEL_W = 8;
    localparam int DELTA_W = 10;
    localparam int DUR_W   = 8;
    localparam int NUM_CH  = 3;
    localparam int CH_W    = 2;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_START_RED      = 2'd0;
    localparam logic [IDX_W-1:0] REG_START_GREEN    = 2'd1;
    localparam logic [IDX_W-1:0] REG_START_BLUE     = 2'd2;
    localparam logic [IDX_W-1:0] REG_START_DURATION = 2'd3;

    typedef struct packed {
        logic               ms_tick;
        logic [LEVEL_W-1:0] next_red;
        logic [LEVEL_W-1:0] next_green;
        logic [LEVEL_W-1:0] next_blue;
        logic [DUR_W-1:0]   next_duration;
    } in_item_t;

    typedef struct packed {
        logic               red_on;
        logic               green_on;
        logic               blue_on;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic               block_taken;
    } out_item_t;

    // Request to and response from the serial divider.
    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] dividend;
        logic [DUR_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_STEP,
        S_BLOCK,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } state_t;

endpackage

// ===== hdl/rlcf_div.sv =====
module rlcf_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  rlcf_pkg::div_req_t req,
    output rlcf_pkg::div_rsp_t rsp
);
    import rlcf_pkg::*;

    localparam int CNT_W = $clog2(LEVEL_W);

    logic [LEVEL_W-1:0] rem_reg, rem_next;
    logic [LEVEL_W-1:0] quo_reg, quo_next;
    logic [DUR_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [LEVEL_W:0]   shifted;
    logic [LEVEL_W:0]   trial;
    logic               fits;

    // One restoring step per cycle: shift in the next dividend bit and try the divisor.
    always_comb begin
        shifted   = {rem_reg, quo_reg[LEVEL_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial[LEVEL_W-1:0] : shifted[LEVEL_W-1:0];
            quo_next = {quo_reg[LEVEL_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(LEVEL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/rgb_led_color_fader_pwm_top.sv =====
// RGB LED color fader with PWM outputs.
//
// The s_ channel takes one item per poll: an optional millisecond tick and
// the color block that the sequencer offers next. For every accepted item
// the m_ channel returns one item with the three PWM pin bits, the three
// levels and a flag that tells the sequencer the offered block was used.
// The cfg port loads the start color and start duration; each write also
// loads the running levels, targets or remaining duration at once.
//
// An item that does not change block passes through the tick, step, block and
// done states before its result is registered. When a fading block is taken,
// the three channel deltas go one after another through one shared bit-serial
// 8-bit divider, so that item takes longer. s_ready is high only while the
// sequencer is idle, so one item is worked on at a time.
// A finished result waits in an output register; the next item is accepted
// while it waits, and that item only stalls at its end if the receiver has
// still not taken the previous result.
// Synchronous reset clears the clocks, phase, levels, targets, deltas and
// duration to zero and empties the output register.
module rgb_led_color_fader_pwm_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rlcf_pkg::IDX_W-1:0] cfg_index,
    input  logic [rlcf_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rlcf_pkg::in_item_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rlcf_pkg::out_item_t        m_data
);
    import rlcf_pkg::*;

    state_t state_reg, state_next;

    logic [MS_W-1:0]    ms_clock_reg, ms_clock_next;
    logic [MS_W-1:0]    last_step_reg, last_step_next;
    logic [LEVEL_W-1:0] phase_reg, phase_next;
    logic [LEVEL_W-1:0] level_reg [NUM_CH];
    logic [LEVEL_W-1:0] level_next [NUM_CH];
    logic [LEVEL_W-1:0] target_reg [NUM_CH];
    logic [LEVEL_W-1:0] target_next [NUM_CH];
    logic [DELTA_W-1:0] delta_reg [NUM_CH];
    logic [DELTA_W-1:0] delta_next [NUM_CH];
    logic [DUR_W-1:0]   dur_reg, dur_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [NUM_CH-1:0]  on_reg, on_next;
    logic               taken_reg, taken_next;
    in_item_t           in_reg, in_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [LEVEL_W-1:0] next_col [NUM_CH];
    logic [MS_W-1:0]    ms_sum;
    logic [MS_W:0]      elapsed;
    logic               step_due;
    logic signed [DELTA_W:0] nudged [NUM_CH];
    logic [LEVEL_W-1:0] cur_level;
    logic [LEVEL_W-1:0] cur_target;
    logic               going_down;
    logic [LEVEL_W:0]   q_plus;
    logic [LEVEL_W:0]   avg_sum;

    rlcf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign next_col[0] = in_reg.next_red;
    assign next_col[1] = in_reg.next_green;
    assign next_col[2] = in_reg.next_blue;

    // Arithmetic shared by the states below.
    always_comb begin
        ms_sum = ms_clock_reg + MS_W'(TICK_MS);
        if (ms_clock_reg >= last_step_reg) begin
            elapsed = {1'b0, ms_clock_reg} - {1'b0, last_step_reg};
        end else begin
            elapsed = (MS_W+1)'(WRAP_MS) - {1'b0, last_step_reg} + {1'b0, ms_clock_reg};
        end
        step_due = (elapsed > (MS_W+1)'(UNIT_MS));
        for (int c = 0; c < NUM_CH; c++) begin
            nudged[c] = $signed({3'b000, level_reg[c]}) + $signed({delta_reg[c][DELTA_W-1],
                        delta_reg[c]});
        end
        cur_level  = level_reg[ch_reg];
        cur_target = target_reg[ch_reg];
        going_down = (cur_level > cur_target);
        q_plus     = {1'b0, div_rsp.quotient} + 1'b1;
        avg_sum    = {1'b0, cur_level} + {1'b0, cur_target};
    end

    // Sequencer and datapath next values.
    always_comb begin
        state_next     = state_reg;
        ms_clock_next  = ms_clock_reg;
        last_step_next = last_step_reg;
        phase_next     = phase_reg;
        level_next     = level_reg;
        target_next    = target_reg;
        delta_next     = delta_reg;
        dur_next       = dur_reg;
        ch_next        = ch_reg;
        on_next        = on_reg;
        taken_next     = taken_reg;
        in_next        = in_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_req        = '{start: 1'b0, dividend: '0, divisor: dur_reg};
        s_ready        = (state_reg == S_IDLE);

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = S_TICK;
                end
            end
            // Advance the millisecond clock and the PWM phase.
            S_TICK: begin
                if (in_reg.ms_tick) begin
                    ms_clock_next = (ms_sum >= MS_W'(WRAP_MS)) ? '0 : ms_sum;
                end
                phase_next = phase_reg + 1'b1;
                state_next = S_STEP;
            end
            // One fade step once more than a unit of time has passed.
            S_STEP: begin
                if (step_due) begin
                    last_step_next = ms_clock_reg;
                    dur_next       = dur_reg - 1'b1;
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (nudged[c] < 0) begin
                            level_next[c] = '0;
                        end else if (nudged[c] > $signed({3'b000, LEVEL_MAX})) begin
                            level_next[c] = LEVEL_MAX;
                        end else begin
                            level_next[c] = nudged[c][LEVEL_W-1:0];
                        end
                    end
                end
                state_next = S_BLOCK;
            end
            // Sample the pins, then take the offered block when the duration ran out.
            S_BLOCK: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    on_next[c] = (phase_reg < level_reg[c]);
                end
                taken_next = (dur_reg == '0);
                ch_next    = '0;
                state_next = S_DONE;
                if (dur_reg == '0) begin
                    dur_next = in_reg.next_duration;
                    for (int c = 0; c < NUM_CH; c++) begin
                        target_next[c] = next_col[c];
                        level_next[c]  = (in_reg.next_duration != '0) ? target_reg[c]
                                                                      : next_col[c];
                    end
                    if (in_reg.next_duration != '0) begin
                        state_next = S_DIV_START;
                    end
                end
            end
            // Divide the channel's distance by the block duration.
            S_DIV_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = going_down ? (cur_level - cur_target)
                                              : (cur_target - cur_level);
                state_next       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient == '0) begin
                        delta_next[ch_reg] = '0;
                        level_next[ch_reg] = avg_sum[LEVEL_W:1];
                    end else if (going_down) begin
                        delta_next[ch_reg] = DELTA_W'(-$signed({1'b0, q_plus}));
                    end else begin
                        delta_next[ch_reg] = DELTA_W'(q_plus);
                    end
                    if (ch_reg == CH_W'(NUM_CH - 1)) begin
                        state_next = S_DONE;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_DIV_START;
                    end
                end
            end
            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.red_on      = on_reg[0];
                    out_next.green_on    = on_reg[1];
                    out_next.blue_on     = on_reg[2];
                    out_next.red_level   = level_reg[0];
                    out_next.green_level = level_reg[1];
                    out_next.blue_level  = level_reg[2];
                    out_next.block_taken = taken_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes load the start values into the running state.
        if (cfg_we) begin
            unique case (cfg_index)
                REG_START_RED: begin
                    level_next[0]  = cfg_wdata;
                    target_next[0] = cfg_wdata;
                end
                REG_START_GREEN: begin
                    level_next[1]  = cfg_wdata;
                    target_next[1] = cfg_wdata;
                end
                REG_START_BLUE: begin
                    level_next[2]  = cfg_wdata;
                    target_next[2] = cfg_wdata;
                end
                REG_START_DURATION: begin
                    dur_next = cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_clock_reg  <= '0;
            last_step_reg <= '0;
            phase_reg     <= '0;
            dur_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                level_reg[c]  <= '0;
                target_reg[c] <= '0;
                delta_reg[c]  <= '0;
            end
        end else begin
            ms_clock_reg  <= ms_clock_next;
            last_step_reg <= last_step_next;
            phase_reg     <= phase_next;
            dur_reg       <= dur_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            level_reg     <= level_next;
            target_reg    <= target_next;
            delta_reg     <= delta_next;
        end
        on_reg    <= on_next;
        taken_reg <= taken_next;
        in_reg    <= in_next;
        out_reg   <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== hdl/rlcf_checker.sv =====
module rlcf_assertions (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rlcf_pkg::out_item_t m_data
);
    import rlcf_pkg::*;

    // Items accepted whose results have not yet been taken.
    logic [1:0] pending_reg, pending_next;

    always_comb begin
        pending_next = pending_reg + 2'(s_valid && s_ready) - 2'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed or dropped while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted item");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more than two items outstanding");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result item without an accepted input item");

endmodule

bind rgb_led_color_fader_pwm_top rlcf_assertions u_rlcf_assertions (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/rlcf_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration port and both item channels of the color fader.
// It keeps its own copy of the fader state and works out the result of every
// accepted poll. Then it compares each returned item with the oldest one
// still outstanding.
module rlcf_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rlcf_pkg::IDX_W-1:0] cfg_index,
    input  logic [rlcf_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  rlcf_pkg::in_item_t         s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  rlcf_pkg::out_item_t        m_data,
    output int                         fail_count,
    output int                         pending_count
);
    import rlcf_pkg::*;

    // Predicted fader state.
    logic [MS_W-1:0]           ms_clock_q;
    logic [MS_W-1:0]           last_step_q;
    logic [LEVEL_W-1:0]        phase_q;
    logic [LEVEL_W-1:0]        level_q [NUM_CH];
    logic [LEVEL_W-1:0]        target_q [NUM_CH];
    logic signed [DELTA_W-1:0] delta_q [NUM_CH];
    logic [DUR_W-1:0]          dur_left_q;

    out_item_t                 expected_levels_q [$];
    int                        mismatches = 0;

    // Per-step delta of one channel: truncated quotient, a nonzero one pushed one
    // further away from zero so that the fade overshoots instead of falling short.
    function automatic int fade_step(input int from, input int to, input int units);
        int d;
        if (from > to) begin
            d = -((from - to) / units);
        end else begin
            d = (to - from) / units;
        end
        if (d > 0) begin
            d++;
        end else if (d < 0) begin
            d--;
        end
        return d;
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_level(input int v);
        if (v < 0) begin
            return '0;
        end else if (v > int'(LEVEL_MAX)) begin
            return LEVEL_MAX;
        end
        return v[LEVEL_W-1:0];
    endfunction

    // One poll: advance the clocks, step the fade when a unit has passed,
    // sample the PWM pins, then take the offered block if the old one ended.
    function automatic out_item_t poll_fader(input in_item_t it);
        out_item_t          res;
        logic [LEVEL_W-1:0] offer [NUM_CH];
        logic [NUM_CH-1:0]  lit;
        int                 elapsed;
        int                 d;
        offer[0] = it.next_red;
        offer[1] = it.next_green;
        offer[2] = it.next_blue;

        if (it.ms_tick) begin
            ms_clock_q = ms_clock_q + MS_W'(TICK_MS);
            if (ms_clock_q >= WRAP_MS) begin
                ms_clock_q = '0;
            end
        end
        phase_q = phase_q + 1'b1;

        // The clock may have wrapped since the last step.
        if (ms_clock_q >= last_step_q) begin
            elapsed = ms_clock_q - last_step_q;
        end else begin
            elapsed = WRAP_MS - last_step_q + ms_clock_q;
        end
        if (elapsed > UNIT_MS) begin
            last_step_q = ms_clock_q;
            dur_left_q  = dur_left_q - 1'b1;
            for (int c = 0; c < NUM_CH; c++) begin
                level_q[c] = clamp_level(int'(level_q[c]) + int'(delta_q[c]));
            end
        end

        for (int c = 0; c < NUM_CH; c++) begin
            lit[c] = (phase_q < level_q[c]);
        end
        res.block_taken = 1'b0;

        // Block change: snap to the old target, then fade toward the new one
        // or jump straight to it when its duration is zero.
        if (dur_left_q == '0) begin
            res.block_taken = 1'b1;
            dur_left_q      = it.next_duration;
            for (int c = 0; c < NUM_CH; c++) begin
                level_q[c]  = target_q[c];
                target_q[c] = offer[c];
                if (it.next_duration != '0) begin
                    d          = fade_step(level_q[c], offer[c], it.next_duration);
                    delta_q[c] = DELTA_W'(d);
                    // A fade too slow for a whole step starts halfway.
                    if (d == 0) begin
                        level_q[c] = LEVEL_W'((int'(offer[c]) + int'(level_q[c])) / 2);
                    end
                end else begin
                    level_q[c] = offer[c];
                end
            end
        end

        res.red_on      = lit[0];
        res.green_on    = lit[1];
        res.blue_on     = lit[2];
        res.red_level   = level_q[0];
        res.green_level = level_q[1];
        res.blue_level  = level_q[2];
        return res;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Track configuration writes, queue a prediction per accepted poll and
    // check every returned item against the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            ms_clock_q  = '0;
            last_step_q = '0;
            phase_q     = '0;
            dur_left_q  = '0;
            for (int c = 0; c < NUM_CH; c++) begin
                level_q[c]  = '0;
                target_q[c] = '0;
                delta_q[c]  = '0;
            end
            expected_levels_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_START_DURATION) begin
                    dur_left_q = cfg_wdata;
                end else begin
                    level_q[cfg_index]  = cfg_wdata;
                    target_q[cfg_index] = cfg_wdata;
                end
            end

            if (s_valid && s_ready) begin
                expected_levels_q.push_back(poll_fader(s_data));
            end

            if (m_valid && m_ready) begin
                if (expected_levels_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item with none expected, got %h", $time, m_data);
                end else begin
                    want = expected_levels_q.pop_front();
                    check_field("red_on", want.red_on, m_data.red_on);
                    check_field("green_on", want.green_on, m_data.green_on);
                    check_field("blue_on", want.blue_on, m_data.blue_on);
                    check_field("red_level", want.red_level, m_data.red_level);
                    check_field("green_level", want.green_level, m_data.green_level);
                    check_field("blue_level", want.blue_level, m_data.blue_level);
                    check_field("block_taken", want.block_taken, m_data.block_taken);
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_levels_q.size();
    end

endmodule

// ===== dv/tb_rgb_led_color_fader_pwm_top.sv =====
`timescale 1ns / 1ps

module tb_rgb_led_color_fader_pwm_top;
    import rlcf_pkg::*;

    localparam int NUM_REGS         = 4;
    localparam int POLLS_PER_PHASE  = 180;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT   = 4000;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;

    int               fail_count;
    int               pending_count;
    int               sender_idle_pct;
    int               receiver_idle_pct;
    bit               long_hold_req;
    int               quiet_cycles;

    // Block currently offered by the emulated sequencer.
    logic [LEVEL_W-1:0] offer_red;
    logic [LEVEL_W-1:0] offer_green;
    logic [LEVEL_W-1:0] offer_blue;
    logic [DUR_W-1:0]   offer_duration;

    rgb_led_color_fader_pwm_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    rlcf_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request so
    // that the fader fills up and stalls its input.
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !held) begin
                held      = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no item moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Offer one poll and hold it until the fader accepts it.
    task automatic send_poll(input logic tick, input logic [LEVEL_W-1:0] red,
                             input logic [LEVEL_W-1:0] green, input logic [LEVEL_W-1:0] blue,
                             input logic [DUR_W-1:0] duration);
        in_item_t it;
        it.ms_tick       = tick;
        it.next_red      = red;
        it.next_green    = green;
        it.next_blue     = blue;
        it.next_duration = duration;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four start registers back to back; the fader must be idle.
    task automatic load_start(input logic [CFG_W-1:0] red, input logic [CFG_W-1:0] green,
                              input logic [CFG_W-1:0] blue, input logic [CFG_W-1:0] duration);
        logic [IDX_W-1:0] regs [NUM_REGS];
        logic [CFG_W-1:0] vals [NUM_REGS];
        regs = '{REG_START_RED, REG_START_GREEN, REG_START_BLUE, REG_START_DURATION};
        vals = '{red, green, blue, duration};
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            return '0;
        end else if (roll < 30) begin
            return LEVEL_MAX;
        end
        return LEVEL_W'($urandom_range(0, 255));
    endfunction

    // Mostly short fades so that blocks turn over often; long ones are rare.
    function automatic logic [DUR_W-1:0] pick_duration();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            return '0;
        end else if (roll < 80) begin
            return DUR_W'($urandom_range(1, 4));
        end else if (roll < 97) begin
            return DUR_W'($urandom_range(5, 40));
        end
        return DUR_W'($urandom_range(41, 255));
    endfunction

    // The sequencer changes its offer now and then; most polls carry a tick.
    task automatic send_random_poll();
        if ($urandom_range(0, 99) < 30) begin
            offer_red      = pick_level();
            offer_green    = pick_level();
            offer_blue     = pick_level();
            offer_duration = pick_duration();
        end
        send_poll($urandom_range(0, 99) < 85, offer_red, offer_green, offer_blue,
                  offer_duration);
    endtask

    initial begin
        aresetn           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_START_RED;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_data            = '0;
        sender_idle_pct   = 36;
        receiver_idle_pct = 56;
        long_hold_req     = 1'b0;
        offer_red         = '0;
        offer_green       = '0;
        offer_blue        = '0;
        offer_duration    = 8'd1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Longest start duration: nothing is taken yet.
        load_start(8'd255, 8'd0, 8'd128, 8'd255);
        send_poll(1'b0, 8'd17, 8'd34, 8'd51, 8'd9);
        send_poll(1'b1, 8'd17, 8'd34, 8'd51, 8'd9);
        wait_results_drained();

        // Fades both ways with saturation, jumps, and a step while the
        // remaining duration is already zero.
        load_start(8'd255, 8'd0, 8'd128, 8'd0);
        send_poll(1'b0, 8'd0, 8'd255, 8'd7, 8'd2);
        repeat (3) send_poll(1'b1, 8'd0, 8'd255, 8'd7, 8'd2);
        repeat (3) send_poll(1'b1, 8'd255, 8'd255, 8'd255, 8'd0);
        send_poll(1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        repeat (3) send_poll(1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
        wait_results_drained();

        // Fade slower than one step per unit: levels start halfway.
        load_start(8'd200, 8'd100, 8'd50, 8'd0);
        send_poll(1'b0, 8'd201, 8'd100, 8'd0, 8'd255);
        send_poll(1'b1, 8'd255, 8'd0, 8'd255, 8'd3);
        wait_results_drained();

        // Random polls with a long receiver hold-off partway through.
        load_start(8'd10, 8'd245, 8'd77, 8'd2);
        for (int i = 0; i < POLLS_PER_PHASE; i++) begin
            if (i == POLLS_PER_PHASE / 3) begin
                long_hold_req <= 1'b1;
            end
            send_random_poll();
        end
        wait_results_drained();

        sender_idle_pct   <= 56;
        receiver_idle_pct <= 36;
        load_start(8'd0, 8'd255, 8'd0, 8'd1);
        repeat (POLLS_PER_PHASE) send_random_poll();
        wait_results_drained();

        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
        load_start(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
                   CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 3)));
        repeat (POLLS_PER_PHASE) send_random_poll();
        wait_results_drained();

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
